### rtl/pwrcs_pkg.sv
package pwrcs_pkg;

    // Register field widths
    localparam int unsigned CODE_W  = 13;
    localparam int unsigned TICK_W  = 8;
    localparam int unsigned INDEX_W = 4;
    localparam int unsigned PHASE_W = 3;
    localparam int unsigned CFG_A_W = 2;

    typedef logic [CODE_W-1:0]  code_t;
    typedef logic [TICK_W-1:0]  tick_t;
    typedef logic [INDEX_W-1:0] index_t;
    typedef logic [PHASE_W-1:0] phase_t;
    typedef logic [CFG_A_W-1:0] cfg_addr_t;

    // Register indexes
    localparam cfg_addr_t REG_DEVICE_CODE    = 2'd0;
    localparam cfg_addr_t REG_PREAMBLE_TICKS = 2'd1;
    localparam cfg_addr_t REG_GAP_TICKS      = 2'd2;
    localparam cfg_addr_t REG_SETTLE_TICKS   = 2'd3;

    // Register reset values
    localparam code_t RST_DEVICE_CODE    = 13'd2730;
    localparam tick_t RST_PREAMBLE_TICKS = 8'd80;
    localparam tick_t RST_GAP_TICKS      = 8'd80;
    localparam tick_t RST_SETTLE_TICKS   = 8'd167;

    // Sequence phases
    localparam phase_t PH_IDLE       = 3'd0;
    localparam phase_t PH_SETTLE_ON  = 3'd1;
    localparam phase_t PH_PREAMBLE   = 3'd2;
    localparam phase_t PH_GAP        = 3'd3;
    localparam phase_t PH_BIT        = 3'd4;
    localparam phase_t PH_SETTLE_OFF = 3'd5;

    // One code bit lasts six units
    localparam tick_t BIT_TICKS = 8'd6;

    // A length written as zero counts as one unit
    function automatic tick_t span(input tick_t v);
        span = (v == '0) ? tick_t'(1) : v;
    endfunction

endpackage

### rtl/pulse_width_remote_code_sender.sv
// Channel   Direction  Handshake           Payload
// s_        in         s_valid / s_ready   s_button_held (one 300 us unit)
// m_        out        m_valid / m_ready   m_rf_level, m_rf_enable, m_busy_res
// cfg_      in         cfg_we              cfg_index, cfg_wdata
//
// One result per request, registered in the cycle after it is accepted; a request is
// taken every cycle while the result register is empty or being drained.
// The phase, unit counter and bit index advance only on an accepted request.
// Reset (aresetn, synchronous, low) returns to idle with registers at defaults.
// A stalled result holds in the output register and holds off s_ready.
module pulse_width_remote_code_sender #(
    parameter int unsigned CODE_BITS = 13
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic                 s_button_held,
    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_rf_level,
    output logic                 m_rf_enable,
    output logic                 m_busy_res,
    input  logic                 cfg_we,
    input  pwrcs_pkg::cfg_addr_t cfg_index,
    input  pwrcs_pkg::code_t     cfg_wdata
);
    import pwrcs_pkg::*;

    localparam index_t LAST_BIT = index_t'(CODE_BITS - 1);

    code_t  device_code_reg;
    tick_t  preamble_ticks_reg;
    tick_t  gap_ticks_reg;
    tick_t  settle_ticks_reg;

    phase_t phase_reg, phase_next;
    tick_t  unit_count_reg, unit_count_next;
    index_t bit_index_reg, bit_index_next;

    logic   m_valid_reg;
    logic   rf_level_reg, rf_enable_reg, busy_res_reg;
    logic   lvl, en, busy;
    logic   s_accept;

    phase_t     cur_phase;
    tick_t      cur_count;
    index_t     cur_index;
    tick_t      count_inc;
    tick_t      len;
    logic       done;
    logic [15:0] code_ext;
    logic       code_bit;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // Configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            device_code_reg    <= RST_DEVICE_CODE;
            preamble_ticks_reg <= RST_PREAMBLE_TICKS;
            gap_ticks_reg      <= RST_GAP_TICKS;
            settle_ticks_reg   <= RST_SETTLE_TICKS;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_DEVICE_CODE:    device_code_reg    <= cfg_wdata;
                REG_PREAMBLE_TICKS: preamble_ticks_reg <= cfg_wdata[TICK_W-1:0];
                REG_GAP_TICKS:      gap_ticks_reg      <= cfg_wdata[TICK_W-1:0];
                REG_SETTLE_TICKS:   settle_ticks_reg   <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Sequence step for one unit
    always_comb begin
        cur_phase = phase_reg;
        cur_count = unit_count_reg;
        cur_index = bit_index_reg;
        lvl       = 1'b0;
        en        = 1'b0;
        busy      = 1'b0;

        // drop unused codes to idle, start on a press
        case (phase_reg)
            PH_SETTLE_ON, PH_PREAMBLE, PH_GAP, PH_BIT, PH_SETTLE_OFF: ;
            default: begin
                cur_phase = PH_IDLE;
                if (s_button_held) begin
                    cur_phase = PH_SETTLE_ON;
                    cur_count = '0;
                    cur_index = '0;
                end
            end
        endcase

        case (cur_phase)
            PH_SETTLE_ON:  len = settle_ticks_reg;
            PH_PREAMBLE:   len = preamble_ticks_reg;
            PH_GAP:        len = gap_ticks_reg;
            PH_BIT:        len = BIT_TICKS;
            PH_SETTLE_OFF: len = settle_ticks_reg;
            default:       len = BIT_TICKS;
        endcase

        count_inc = cur_count + tick_t'(1);
        done      = (count_inc >= span(len));

        code_ext = 16'(device_code_reg);
        code_bit = code_ext[cur_index];

        phase_next      = cur_phase;
        unit_count_next = done ? '0 : count_inc;
        bit_index_next  = cur_index;

        case (cur_phase)
            PH_SETTLE_ON: begin
                en   = 1'b1;
                busy = 1'b1;
                if (done) phase_next = PH_PREAMBLE;
            end
            PH_PREAMBLE: begin
                lvl  = 1'b1;
                en   = 1'b1;
                busy = 1'b1;
                if (done) phase_next = s_button_held ? PH_GAP : PH_SETTLE_OFF;
            end
            PH_GAP: begin
                en   = 1'b1;
                busy = 1'b1;
                if (done) begin
                    phase_next     = PH_BIT;
                    bit_index_next = '0;
                end
            end
            PH_BIT: begin
                en   = 1'b1;
                busy = 1'b1;
                if (code_bit) lvl = (cur_count >= 8'd1) && (cur_count <= 8'd4);
                else          lvl = (cur_count == 8'd3) || (cur_count == 8'd4);
                if (done) begin
                    if (cur_index >= LAST_BIT) begin
                        bit_index_next = '0;
                        phase_next     = s_button_held ? PH_GAP : PH_SETTLE_OFF;
                    end else begin
                        bit_index_next = cur_index + index_t'(1);
                    end
                end
            end
            PH_SETTLE_OFF: begin
                busy = 1'b1;
                if (done) phase_next = PH_IDLE;
            end
            default: begin
                unit_count_next = cur_count;
            end
        endcase
    end

    // Advance sequence state on each accepted request
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_IDLE;
            unit_count_reg <= '0;
            bit_index_reg  <= '0;
        end else if (s_accept) begin
            phase_reg      <= phase_next;
            unit_count_reg <= unit_count_next;
            bit_index_reg  <= bit_index_next;
        end
    end

    // Hold the result until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= s_accept || (m_valid_reg && !m_ready);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            rf_level_reg  <= lvl;
            rf_enable_reg <= en;
            busy_res_reg  <= busy;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_rf_level  = rf_level_reg;
    assign m_rf_enable = rf_enable_reg;
    assign m_busy_res  = busy_res_reg;

`ifndef NO_ASSERTIONS
    a_level_needs_enable: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rf_level_reg) |-> rf_enable_reg)
        else $error("carrier keyed while transmitter unpowered");

    a_enable_needs_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && rf_enable_reg) |-> busy_res_reg)
        else $error("transmitter powered outside a send sequence");

    a_idle_count_clear: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == PH_IDLE) |-> (unit_count_reg == '0))
        else $error("unit counter not cleared in idle");

    a_bit_index_range: assert property (@(posedge aclk) disable iff (!aresetn)
        bit_index_reg <= LAST_BIT)
        else $error("bit index beyond code length");
`endif

endmodule

### sim/tb_top.sv
module tb_top;
    import pwrcs_pkg::*;

    localparam int unsigned SENT_BITS   = 13;
    localparam int unsigned LIMIT       = 600000;
    localparam int unsigned LONG_HOLD   = 150;
    localparam int unsigned SMALL_UNITS = 400;
    localparam int unsigned PLAN_LEN    = 17;

    typedef struct packed {
        logic rf_level;
        logic rf_enable;
        logic busy_res;
    } keying_t;

    // Typical result patterns, read straight off the sequence description
    localparam keying_t KEY_IDLE      = 3'b000;
    localparam keying_t KEY_POWERED   = 3'b011;
    localparam keying_t KEY_CARRIER   = 3'b111;
    localparam keying_t KEY_WIND_DOWN = 3'b001;

    typedef enum logic {ROW_UNIT, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        cfg_addr_t idx;
        code_t     data;
        logic      btn;
        logic      check;
        keying_t   want;
    } plan_row_t;

    logic      aclk;
    logic      aresetn;
    logic      s_valid;
    logic      s_ready;
    logic      s_button_held;
    logic      m_valid;
    logic      m_ready;
    logic      m_rf_level;
    logic      m_rf_enable;
    logic      m_busy_res;
    logic      cfg_we;
    cfg_addr_t cfg_index;
    code_t     cfg_wdata;

    // Shadow copy of the registers and the sequencer state
    code_t  cur_code;
    tick_t  cur_preamble;
    tick_t  cur_gap;
    tick_t  cur_settle;
    phase_t pw_phase;
    tick_t  pw_units;
    index_t pw_bit;

    keying_t     owed_keying[$];
    plan_row_t   plan[PLAN_LEN];
    int unsigned errors     = 0;
    int unsigned units_sent = 0;
    int unsigned cycle_cnt  = 0;
    bit          src_steady    = 1'b0;
    bit          sink_steady   = 1'b0;
    bit          long_hold_req = 1'b0;

    pulse_width_remote_code_sender #(
        .CODE_BITS (SENT_BITS)
    ) dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_button_held (s_button_held),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_rf_level    (m_rf_level),
        .m_rf_enable   (m_rf_enable),
        .m_busy_res    (m_busy_res),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Abort a hung run
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == LIMIT) begin
            $display("Verification failed");
            $finish;
        end
    end

    // Count one unit of the current phase; true when the phase ends
    function automatic logic unit_done(input tick_t len);
        tick_t lim;
        lim = (len == '0) ? tick_t'(1) : len;
        pw_units = pw_units + tick_t'(1);
        if (pw_units >= lim) begin
            pw_units = '0;
            return 1'b1;
        end
        return 1'b0;
    endfunction

    // Advance the sequencer by one 300 us unit and return the keying it produces
    function automatic keying_t key_next_unit(input logic btn);
        keying_t k;
        code_t   shifted;
        logic    mark;
        k = KEY_IDLE;
        if (pw_phase == PH_IDLE || pw_phase > PH_SETTLE_OFF) begin
            pw_phase = PH_IDLE;
            if (btn) begin
                pw_phase = PH_SETTLE_ON;
                pw_units = '0;
                pw_bit   = '0;
            end
        end
        case (pw_phase)
            PH_SETTLE_ON: begin
                k = KEY_POWERED;
                if (unit_done(cur_settle)) pw_phase = PH_PREAMBLE;
            end
            PH_PREAMBLE: begin
                k = KEY_CARRIER;
                if (unit_done(cur_preamble)) pw_phase = btn ? PH_GAP : PH_SETTLE_OFF;
            end
            PH_GAP: begin
                k = KEY_POWERED;
                if (unit_done(cur_gap)) begin
                    pw_phase = PH_BIT;
                    pw_bit   = '0;
                end
            end
            PH_BIT: begin
                shifted     = cur_code >> pw_bit;
                mark        = shifted[0];
                k           = KEY_POWERED;
                // one: low, four high, low; zero: three low, two high, low
                if (mark) k.rf_level = (pw_units >= 1 && pw_units <= 4);
                else      k.rf_level = (pw_units == 3 || pw_units == 4);
                if (unit_done(BIT_TICKS)) begin
                    if (pw_bit >= SENT_BITS - 1) begin
                        pw_bit   = '0;
                        pw_phase = btn ? PH_GAP : PH_SETTLE_OFF;
                    end else begin
                        pw_bit = pw_bit + index_t'(1);
                    end
                end
            end
            PH_SETTLE_OFF: begin
                k = KEY_WIND_DOWN;
                if (unit_done(cur_settle)) pw_phase = PH_IDLE;
            end
            default: ;
        endcase
        return k;
    endfunction

    function automatic plan_row_t unit_row(input logic btn, input logic check,
                                           input keying_t want);
        plan_row_t r;
        r       = '0;
        r.kind  = ROW_UNIT;
        r.btn   = btn;
        r.check = check;
        r.want  = want;
        return r;
    endfunction

    function automatic plan_row_t reg_row(input cfg_addr_t idx, input code_t data);
        plan_row_t r;
        r      = '0;
        r.kind = ROW_CFG;
        r.idx  = idx;
        r.data = data;
        return r;
    endfunction

    function automatic tick_t draw_tick();
        if ($urandom_range(0, 5) == 0) return tick_t'($urandom_range(6, 30));
        return tick_t'($urandom_range(0, 5));
    endfunction

    // Write one register and mirror it into the shadow copy
    task automatic write_reg(input cfg_addr_t idx, input code_t data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge aclk);
        case (idx)
            REG_DEVICE_CODE:    cur_code     = data;
            REG_PREAMBLE_TICKS: cur_preamble = data[TICK_W-1:0];
            REG_GAP_TICKS:      cur_gap      = data[TICK_W-1:0];
            REG_SETTLE_TICKS:   cur_settle   = data[TICK_W-1:0];
            default: ;
        endcase
    endtask

    // Offer one request after a random gap; record its keying once taken
    task automatic offer_unit(input logic btn, input logic typed, input keying_t want);
        int unsigned gap;
        keying_t     k;
        gap = src_steady ? 0 : $urandom_range(0, 19);
        if (gap != 0) begin
            s_valid       <= 1'b0;
            s_button_held <= 1'($urandom_range(0, 1));
            repeat (gap) @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_button_held <= btn;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        k = key_next_unit(btn);
        owed_keying.push_back(typed ? want : k);
        units_sent++;
    endtask

    // Hold the input and let every owed result come back
    task automatic wait_results();
        s_valid <= 1'b0;
        while (owed_keying.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // Run out any open sequence, drain, then load a new register set
    task automatic apply_settings(input code_t code, input tick_t pre, input tick_t gap,
                                  input tick_t settle);
        code_t padded;
        while (pw_phase != PH_IDLE) offer_unit(1'b0, 1'b0, KEY_IDLE);
        wait_results();
        write_reg(REG_DEVICE_CODE, code);
        padded = code_t'($urandom);
        padded[TICK_W-1:0] = pre;
        write_reg(REG_PREAMBLE_TICKS, padded);
        padded = code_t'($urandom);
        padded[TICK_W-1:0] = gap;
        write_reg(REG_GAP_TICKS, padded);
        padded = code_t'($urandom);
        padded[TICK_W-1:0] = settle;
        write_reg(REG_SETTLE_TICKS, padded);
        cfg_we <= 1'b0;
    endtask

    // Mostly button presses of random length, some noise, some full drains
    task automatic run_small_phase(input int unsigned budget);
        int unsigned start;
        int unsigned head;
        int unsigned frame;
        int unsigned hold;
        int unsigned rest;
        int unsigned n;
        start = units_sent;
        head  = (cur_settle == 0 ? 1 : cur_settle) + (cur_preamble == 0 ? 1 : cur_preamble);
        frame = (cur_gap == 0 ? 1 : cur_gap) + SENT_BITS * BIT_TICKS;
        while (units_sent - start < budget) begin
            case ($urandom_range(0, 9))
                0, 1: begin
                    n = $urandom_range(1, 20);
                    repeat (n) offer_unit(1'($urandom_range(0, 1)), 1'b0, KEY_IDLE);
                end
                2: wait_results();
                default: begin
                    if ($urandom_range(0, 1) == 0) hold = $urandom_range(1, head + 3);
                    else                           hold = $urandom_range(1, head + 2 * frame);
                    rest = $urandom_range(0, (cur_settle == 0 ? 1 : cur_settle) + 3);
                    repeat (hold) offer_unit(1'b1, 1'b0, KEY_IDLE);
                    repeat (rest) offer_unit(1'b0, 1'b0, KEY_IDLE);
                end
            endcase
        end
    endtask

    // Result side: random stalls, one long hold on request, field checks
    initial begin : result_sink
        int unsigned stall;
        keying_t     want;
        m_ready <= 1'b0;
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            if (long_hold_req) begin
                stall         = LONG_HOLD;
                long_hold_req = 1'b0;
            end else if (sink_steady) begin
                stall = 0;
            end else begin
                stall = $urandom_range(0, 19);
            end
            if (stall != 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(posedge aclk);
            end
            m_ready <= 1'b1;
            @(posedge aclk);
            while (!m_valid) @(posedge aclk);
            if (owed_keying.size() == 0) begin
                $error("result with no request pending: rf_level %0b rf_enable %0b busy_res %0b",
                       m_rf_level, m_rf_enable, m_busy_res);
                errors++;
            end else begin
                want = owed_keying.pop_front();
                if (m_rf_level !== want.rf_level) begin
                    $error("rf_level: expected %0b, got %0b", want.rf_level, m_rf_level);
                    errors++;
                end
                if (m_rf_enable !== want.rf_enable) begin
                    $error("rf_enable: expected %0b, got %0b", want.rf_enable, m_rf_enable);
                    errors++;
                end
                if (m_busy_res !== want.busy_res) begin
                    $error("busy_res: expected %0b, got %0b", want.busy_res, m_busy_res);
                    errors++;
                end
            end
        end
    end

    initial begin : stimulus
        int unsigned k;
        int unsigned small_start;
        code_t       code;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_button_held <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_index     <= REG_DEVICE_CODE;
        cfg_wdata     <= '0;

        // Shadow state at reset
        cur_code     = RST_DEVICE_CODE;
        cur_preamble = RST_PREAMBLE_TICKS;
        cur_gap      = RST_GAP_TICKS;
        cur_settle   = RST_SETTLE_TICKS;
        pw_phase     = PH_IDLE;
        pw_units     = '0;
        pw_bit       = '0;

        // Directed: idle, zero lengths, release after preamble, re-press
        // during wind-down, hold into the first code bit
        plan[0]  = unit_row(1'b0, 1'b1, KEY_IDLE);
        plan[1]  = reg_row(REG_DEVICE_CODE, 13'h1FFF);
        plan[2]  = reg_row(REG_PREAMBLE_TICKS, 13'h0000);
        plan[3]  = reg_row(REG_GAP_TICKS, 13'h0000);
        plan[4]  = reg_row(REG_SETTLE_TICKS, 13'h0000);
        plan[5]  = unit_row(1'b1, 1'b1, KEY_POWERED);
        plan[6]  = unit_row(1'b0, 1'b1, KEY_CARRIER);
        plan[7]  = unit_row(1'b1, 1'b1, KEY_WIND_DOWN);
        plan[8]  = unit_row(1'b1, 1'b1, KEY_POWERED);
        plan[9]  = unit_row(1'b1, 1'b1, KEY_CARRIER);
        plan[10] = unit_row(1'b0, 1'b1, KEY_POWERED);
        plan[11] = unit_row(1'b1, 1'b0, KEY_IDLE);
        plan[12] = unit_row(1'b0, 1'b0, KEY_IDLE);
        plan[13] = unit_row(1'b1, 1'b0, KEY_IDLE);
        plan[14] = unit_row(1'b0, 1'b0, KEY_IDLE);
        plan[15] = unit_row(1'b0, 1'b0, KEY_IDLE);
        plan[16] = unit_row(1'b1, 1'b0, KEY_IDLE);

        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // Walk the directed table
        for (int i = 0; i < PLAN_LEN; i++) begin
            if (plan[i].kind == ROW_CFG) begin
                if (!cfg_we) wait_results();
                write_reg(plan[i].idx, plan[i].data);
            end else begin
                if (cfg_we) cfg_we <= 1'b0;
                offer_unit(plan[i].btn, plan[i].check, plan[i].want);
            end
        end

        // Longest preamble, all-ones code, one full frame, release on the last bit
        apply_settings(13'h1FFF, tick_t'(255), tick_t'(0), tick_t'(0));
        repeat (334) offer_unit(1'b1, 1'b0, KEY_IDLE);
        repeat (2) offer_unit(1'b0, 1'b0, KEY_IDLE);

        // Random phases with short lengths
        k           = 0;
        small_start = units_sent;
        while (units_sent - small_start < SMALL_UNITS || k < 4) begin
            if (k == 0)      code = '0;
            else if (k == 1) code = '1;
            else             code = code_t'($urandom);
            if (k == 3) apply_settings(code, tick_t'(1), tick_t'(1), tick_t'(1));
            else        apply_settings(code, draw_tick(), draw_tick(), draw_tick());
            src_steady  = ($urandom_range(0, 3) == 0);
            sink_steady = ($urandom_range(0, 3) == 0);
            // back up the result side while requests keep coming
            if (k == 2) begin
                src_steady    = 1'b1;
                sink_steady   = 1'b0;
                long_hold_req = 1'b1;
            end
            run_small_phase($urandom_range(40, 100));
            k++;
        end

        wait_results();
        repeat (8) @(posedge aclk);
        if (errors == 0) $display("Verification passed");
        else             $display("Verification failed");
        $finish;
    end

endmodule
